/* hw/rtl/mlf_pkg.sv */
// ----------------------------------------------------------------------------
// mlf_pkg
// Shared types, codes and constants of the multichannel linear fade unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mlf_pkg;

   // Gain is unsigned Q1.23 in the range 0 .. 2^23.
   localparam int GAIN_FRAC = 23;
   localparam int GAIN_BITS = 24;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE = 24'h80_0000;

   // Step divider runs one quotient bit per cycle.
   localparam int DIV_COUNT_BITS = 5;
   localparam logic [DIV_COUNT_BITS-1:0] DIV_LAST_BIT = 5'(GAIN_BITS - 1);

   localparam int MODE_BITS     = 2;
   localparam int CHANNEL_BITS  = 4;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [MODE_BITS-1:0] MODE_FADE_IN  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FADE_OUT = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_MODE       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_CHANNELS = 2'd2;

   localparam logic [MODE_BITS-1:0]    RESET_MODE     = 2'd0;
   localparam logic [CHANNEL_BITS-1:0] RESET_CHANNELS = 4'd2;
   localparam longint unsigned         RESET_FRAMES   = 64'd1024;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;

   // Per-frame controls that travel with the samples from front to back.
   typedef struct packed {
      logic [GAIN_BITS-1:0] gain;
      logic                 fading;
      logic                 last;
   } ramp_meta_type;

   localparam int META_BITS = GAIN_BITS + 2;

   function automatic logic [GAIN_BITS-1:0] start_gain(
      input logic [MODE_BITS-1:0] mode,
      input logic [GAIN_BITS-1:0] step
   );
      logic [GAIN_BITS-1:0] g;
      case (mode)
         MODE_FADE_IN:  g = '0;
         MODE_FADE_OUT: g = GAIN_ONE - step;
         default:       g = GAIN_ONE;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/mlf_step_div.sv */
// ----------------------------------------------------------------------------
// mlf_step_div
// Restoring divider that forms floor(2^23 / divisor), one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mlf_step_div
   import mlf_pkg::*;
#(
   parameter int FRAME_COUNT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [FRAME_COUNT_BITS-1:0] divisor,
   output logic                             busy,
   output logic                             done,
   output logic [GAIN_BITS-1:0]             quotient
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [DIV_COUNT_BITS-1:0]   count_ff, count_in;
   logic [FRAME_COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic [FRAME_COUNT_BITS-1:0] rem_ff, rem_in;
   logic [GAIN_BITS-1:0]        quot_ff, quot_in;
   logic [FRAME_COUNT_BITS:0]   trial;
   logic                        fits;

   // The dividend is 2^23, so its only set bit enters on the first step.
   assign trial = {rem_ff, (count_ff == '0)};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         divisor_in = divisor;
         rem_in     = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? FRAME_COUNT_BITS'(trial - {1'b0, divisor_ff})
                         : trial[FRAME_COUNT_BITS-1:0];
         quot_in  = {quot_ff[GAIN_BITS-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_LAST_BIT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

/* hw/rtl/mlf_front.sv */
// ----------------------------------------------------------------------------
// mlf_front
// Accepts requests, holds the configuration and ramp state, and tags each
// frame with its gain, lane enables and end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mlf_front
   import mlf_pkg::*;
#(
   parameter int LANES            = 8,
   parameter int SAMPLE_BITS      = 24,
   parameter int FRAME_COUNT_BITS = 16,
   parameter int CSR_DATA_BITS    = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]     csr_wdata,
   input  wire logic                         req_valid,
   input  wire logic [LANES*SAMPLE_BITS-1:0] req_samples,
   output logic                              req_ready,
   input  wire logic                         queue_full,
   output logic                              push,
   output logic [LANES*SAMPLE_BITS-1:0]      push_samples,
   output logic [LANES-1:0]                  push_lane_en,
   output ramp_meta_type                     push_meta
);

   localparam longint unsigned FC_MOD    = 64'd1 << FRAME_COUNT_BITS;
   localparam longint unsigned FC_RESET  = RESET_FRAMES % FC_MOD;
   localparam longint unsigned RUN_RESET = (FC_RESET == 0) ? 64'd1 : FC_RESET;
   localparam logic [GAIN_BITS-1:0] RESET_STEP = GAIN_BITS'(64'd8388608 / RUN_RESET);

   logic [MODE_BITS-1:0]        mode_ff, mode_in;
   logic [FRAME_COUNT_BITS-1:0] frames_ff, frames_in;
   logic [CHANNEL_BITS-1:0]     channels_ff, channels_in;
   logic [GAIN_BITS-1:0]        gain_ff, gain_in;
   logic [GAIN_BITS-1:0]        step_ff, step_in;
   logic [FRAME_COUNT_BITS-1:0] index_ff, index_in;

   logic                        div_start;
   logic                        div_busy;
   logic                        div_done;
   logic [GAIN_BITS-1:0]        div_quot;
   logic [FRAME_COUNT_BITS-1:0] new_frames;
   logic [FRAME_COUNT_BITS-1:0] new_run;
   logic [FRAME_COUNT_BITS-1:0] run_len;
   logic                        last;
   logic                        fading;
   logic [GAIN_BITS:0]          gain_sum;

   assign new_frames = csr_wdata[FRAME_COUNT_BITS-1:0];
   assign new_run    = (new_frames == '0) ? FRAME_COUNT_BITS'(1) : new_frames;
   assign run_len    = (frames_ff == '0) ? FRAME_COUNT_BITS'(1) : frames_ff;
   assign div_start  = csr_wr_en && (csr_index == CSR_FRAME_COUNT);

   mlf_step_div #(
      .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
   ) u_step_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (new_run),
      .busy    (div_busy),
      .done    (div_done),
      .quotient(div_quot)
   );

   // Register writes and the ramp restart after a new step both own the ramp
   // state in their cycle, so no request is taken then, nor while the divider is busy or the queue is full.
   assign req_ready = !div_busy && !div_done && !csr_wr_en && !queue_full;
   assign push      = req_valid && req_ready;

   assign last     = ({1'b0, index_ff} + 1'b1) >= {1'b0, run_len};
   assign fading   = (mode_ff == MODE_FADE_IN) || (mode_ff == MODE_FADE_OUT);
   assign gain_sum = {1'b0, gain_ff} + {1'b0, step_ff};

   always_comb begin
      mode_in     = mode_ff;
      frames_in   = frames_ff;
      channels_in = channels_ff;
      gain_in     = gain_ff;
      step_in     = div_done ? div_quot : step_ff;
      index_in    = index_ff;
      if (div_done) begin
         // A new run length restarts the ramp once its step is known.
         gain_in = start_gain(mode_ff, div_quot);
      end
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FADE_MODE: begin
               mode_in  = csr_wdata[MODE_BITS-1:0];
               index_in = '0;
               gain_in  = start_gain(csr_wdata[MODE_BITS-1:0], step_in);
            end
            CSR_FRAME_COUNT: begin
               frames_in = new_frames;
               index_in  = '0;
            end
            CSR_ACTIVE_CHANNELS: begin
               channels_in = csr_wdata[CHANNEL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end else if (push) begin
         if (last) begin
            index_in = '0;
            gain_in  = start_gain(mode_ff, step_ff);
         end else begin
            index_in = index_ff + 1'b1;
            case (mode_ff)
               MODE_FADE_IN:
                  gain_in = (gain_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE
                                                         : gain_sum[GAIN_BITS-1:0];
               MODE_FADE_OUT:
                  gain_in = (gain_ff > step_ff) ? GAIN_BITS'(gain_ff - step_ff) : '0;
               default:
                  gain_in = gain_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= RESET_MODE;
         frames_ff   <= FRAME_COUNT_BITS'(FC_RESET);
         channels_ff <= RESET_CHANNELS;
         gain_ff     <= start_gain(RESET_MODE, RESET_STEP);
         step_ff     <= RESET_STEP;
         index_ff    <= '0;
      end else begin
         mode_ff     <= mode_in;
         frames_ff   <= frames_in;
         channels_ff <= channels_in;
         gain_ff     <= gain_in;
         step_ff     <= step_in;
         index_ff    <= index_in;
      end
   end

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         push_lane_en[j] = (j < int'(channels_ff));
      end
   end

   assign push_samples     = req_samples;
   assign push_meta.gain   = gain_ff;
   assign push_meta.fading = fading;
   assign push_meta.last   = last;

endmodule

`default_nettype wire

/* hw/rtl/mlf_queue.sv */
// ----------------------------------------------------------------------------
// mlf_queue
// Two-entry queue that decouples the front from the multiply stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mlf_queue
   import mlf_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      head
);

   logic [WIDTH-1:0]          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* hw/rtl/mlf_back.sv */
// ----------------------------------------------------------------------------
// mlf_back
// Lane multipliers and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlf_back
   import mlf_pkg::*;
#(
   parameter int LANES       = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         head_valid,
   input  wire logic [LANES*SAMPLE_BITS-1:0] head_samples,
   input  wire logic [LANES-1:0]             head_lane_en,
   input  wire ramp_meta_type                head_meta,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [LANES*SAMPLE_BITS-1:0]      rsp_faded,
   output logic                              rsp_last
);

   logic                         valid_ff, valid_in;
   logic [LANES*SAMPLE_BITS-1:0] faded_ff, faded_in;
   logic                         last_ff;
   logic signed [GAIN_BITS:0]    gain_s;

   assign pop      = head_valid && (!valid_ff || rsp_ready);
   assign gain_s   = {1'b0, head_meta.gain};
   assign valid_in = pop || (valid_ff && !rsp_ready);

   always_comb begin
      logic signed [SAMPLE_BITS-1:0]           s;
      logic signed [SAMPLE_BITS+GAIN_BITS:0]   prod;
      for (int j = 0; j < LANES; j++) begin
         s    = head_samples[j*SAMPLE_BITS +: SAMPLE_BITS];
         prod = s * gain_s;
         if (!head_lane_en[j]) begin
            faded_in[j*SAMPLE_BITS +: SAMPLE_BITS] = '0;
         end else if (head_meta.fading) begin
            // Taking the bits above the fraction floors toward minus infinity.
            faded_in[j*SAMPLE_BITS +: SAMPLE_BITS] = prod[GAIN_FRAC +: SAMPLE_BITS];
         end else begin
            faded_in[j*SAMPLE_BITS +: SAMPLE_BITS] = s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (pop) begin
         faded_ff <= faded_in;
         last_ff  <= head_meta.last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_faded = faded_ff;
   assign rsp_last  = last_ff;

endmodule

`default_nettype wire

/* hw/rtl/multichannel_linear_fade_unit.sv */
// ----------------------------------------------------------------------------
// multichannel_linear_fade_unit
// Linear gain ramp (fade in / fade out) over runs of multichannel frames.
// ----------------------------------------------------------------------------
// The unit takes one frame per cycle while req_tready is high, and returns one
// response per frame; each response passes through the queue entry and then the
// response register, and waits there until the response side is ready. Writing
// frame_count starts a bit-serial step divider, and no request is taken after
// that write while it forms the new step and restarts the ramp. Other register
// writes take effect at once, and no request is taken in the cycle of any
// register write. tlast marks the final frame of each ramp run.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_linear_fade_unit
   import mlf_pkg::*;
#(
   parameter int LANES            = 8,
   parameter int SAMPLE_BITS      = 24,
   parameter int FRAME_COUNT_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [((FRAME_COUNT_BITS > CHANNEL_BITS) ?
                       FRAME_COUNT_BITS : CHANNEL_BITS)-1:0] csr_wdata,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // sample_0 .. sample_(LANES-1), zero padded to whole bytes
   input  wire logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // faded_0 .. faded_(LANES-1), zero padded to whole bytes
   output logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int CSR_DATA_BITS = (FRAME_COUNT_BITS > CHANNEL_BITS) ?
                                  FRAME_COUNT_BITS : CHANNEL_BITS;
   localparam int LANE_DATA_BITS = LANES * SAMPLE_BITS;
   localparam int BUS_BITS       = ((LANE_DATA_BITS + 7) / 8) * 8;
   localparam int ENTRY_BITS     = LANE_DATA_BITS + LANES + META_BITS;

   logic                      push;
   logic [LANE_DATA_BITS-1:0] push_samples;
   logic [LANES-1:0]          push_lane_en;
   ramp_meta_type             push_meta;
   logic                      queue_full;
   logic                      queue_valid;
   logic                      pop;
   logic [ENTRY_BITS-1:0]     head;
   logic [LANE_DATA_BITS-1:0] rsp_faded;

   mlf_front #(
      .LANES           (LANES),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .FRAME_COUNT_BITS(FRAME_COUNT_BITS),
      .CSR_DATA_BITS   (CSR_DATA_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_tvalid),
      .req_samples (req_tdata[LANE_DATA_BITS-1:0]),
      .req_ready   (req_tready),
      .queue_full  (queue_full),
      .push        (push),
      .push_samples(push_samples),
      .push_lane_en(push_lane_en),
      .push_meta   (push_meta)
   );

   mlf_queue #(
      .WIDTH(ENTRY_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_meta, push_lane_en, push_samples}),
      .pop      (pop),
      .full     (queue_full),
      .not_empty(queue_valid),
      .head     (head)
   );

   mlf_back #(
      .LANES      (LANES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (queue_valid),
      .head_samples(head[LANE_DATA_BITS-1:0]),
      .head_lane_en(head[LANE_DATA_BITS +: LANES]),
      .head_meta   (ramp_meta_type'(head[LANE_DATA_BITS+LANES +: META_BITS])),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_faded   (rsp_faded),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = BUS_BITS'(rsp_faded);

endmodule

`default_nettype wire
